### rtl/core/assert_macros.svh
// assertion macros used by the escape-time fractal pixel block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication checked on every rising clk edge outside reset
`define ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

### rtl/core/etfp_pkg.sv
// shared types and constants of the escape-time fractal pixel block
package etfp_pkg;

  localparam int DIV_BITS = 58;
  localparam int DIV_CW   = $clog2(DIV_BITS + 1);
  localparam int SPAN_W   = 11;
  localparam int MULA_W   = 58;
  localparam int MULB_W   = 12;
  localparam int ACC_W    = 64;
  localparam int C_W      = 22;

  localparam logic [2:0] REG_SCALE    = 3'd0;
  localparam logic [2:0] REG_MAX_ITER = 3'd1;
  localparam logic [2:0] REG_FUNC     = 3'd2;
  localparam logic [2:0] REG_WIDTH    = 3'd3;
  localparam logic [2:0] REG_HEIGHT   = 3'd4;

  localparam logic [2:0] FN_ABS_IMAG = 3'd1;
  localparam logic [2:0] FN_POW_MAX  = 3'd6;

  typedef enum logic [1:0] {
    MAC_HOLD = 2'd0,
    MAC_LOAD = 2'd1,
    MAC_ADD  = 2'd2,
    MAC_SUB  = 2'd3
  } mac_op_t;

  typedef enum logic [1:0] {
    TAG_CX = 2'd0,
    TAG_CY = 2'd1,
    TAG_ZR = 2'd2,
    TAG_ZI = 2'd3
  } div_tag_t;

  typedef struct packed {
    mac_op_t           op;
    logic [MULA_W-1:0] a;
    logic [MULB_W-1:0] b;
  } mac_cmd_t;

  typedef struct packed {
    logic              start;
    logic [ACC_W-1:0]  dividend;
    logic [SPAN_W-1:0] divisor;
  } div_cmd_t;

endpackage

### rtl/core/etfp_mac.sv
// shared signed multiply-accumulate unit
module etfp_mac (
  input  logic                              clk,
  input  etfp_pkg::mac_cmd_t                cmd,
  output logic signed [etfp_pkg::ACC_W-1:0] acc
);
  import etfp_pkg::*;

  logic signed [MULA_W+MULB_W-1:0] prod;
  logic signed [ACC_W-1:0]         prod_t;

  assign prod   = $signed(cmd.a) * $signed(cmd.b);
  assign prod_t = prod[ACC_W-1:0];

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      MAC_LOAD: acc <= prod_t;
      MAC_ADD:  acc <= acc + prod_t;
      MAC_SUB:  acc <= acc - prod_t;
      default:  acc <= acc;
    endcase
  end

endmodule

### rtl/core/etfp_div.sv
// iterative restoring divider, signed dividend, truncating quotient
module etfp_div (
  input  logic                              clk,
  input  logic                              rst,
  input  etfp_pkg::div_cmd_t                cmd,
  output logic                              done,
  output logic signed [etfp_pkg::ACC_W-1:0] quotient
);
  import etfp_pkg::*;

  logic                busy;
  logic [DIV_CW-1:0]   cnt;
  logic                neg;
  logic [DIV_BITS-1:0] dvd;
  logic [DIV_BITS-1:0] quo;
  logic [SPAN_W-1:0]   dsr;
  logic [SPAN_W-1:0]   rem;
  logic [SPAN_W-1:0]   rem_next;
  logic [SPAN_W:0]     trial;
  logic                qbit;
  logic [ACC_W-1:0]    mag;

  assign mag      = cmd.dividend[ACC_W-1] ? (ACC_W'(0) - cmd.dividend) : cmd.dividend;
  assign trial    = {rem, dvd[DIV_BITS-1]};
  assign qbit     = trial >= {1'b0, dsr};
  assign rem_next = qbit ? SPAN_W'(trial - {1'b0, dsr}) : trial[SPAN_W-1:0];
  assign quotient = neg ? $signed(ACC_W'(0) - ACC_W'(quo)) : $signed(ACC_W'(quo));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CW'(DIV_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      neg <= cmd.dividend[ACC_W-1];
      dvd <= mag[DIV_BITS-1:0];
      dsr <= cmd.divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[DIV_BITS-2:0], 1'b0};
      quo <= {quo[DIV_BITS-2:0], qbit};
    end
  end

endmodule

### rtl/core/escape_time_fractal_pixel.sv
// escape-time test of one pixel: maps it to c and iterates z^p+c on a shared mac and divider
// a step runs p-1 complex mults in states CM0 to CM4, two divisions by scale, the head state
//   and the escape test in states ESC, SQR, SQI and CMP
// throughput: one pixel at a time; the serial divider (one quotient bit a cycle) sets the pace
// the next pixel is taken once the result register has been handed on or is free
// reset (rst, synchronous): registers go to scale 50, max_iter 50, func 2, width 39, height 39
module escape_time_fractal_pixel (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [9:0] pixel_x, [19:10] pixel_y, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] inside_res, rest zero
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import etfp_pkg::*;

  // sequencer states, one-hot
  typedef enum logic [19:0] {
    S_IDLE  = 20'd1 << 0,
    S_MAPX  = 20'd1 << 1,
    S_DMX   = 20'd1 << 2,
    S_MAPY  = 20'd1 << 3,
    S_DMY   = 20'd1 << 4,
    S_DWAIT = 20'd1 << 5,
    S_HEAD  = 20'd1 << 6,
    S_CM0   = 20'd1 << 7,
    S_CM1   = 20'd1 << 8,
    S_CM2   = 20'd1 << 9,
    S_CM3   = 20'd1 << 10,
    S_CM4   = 20'd1 << 11,
    S_DRE   = 20'd1 << 12,
    S_DIM   = 20'd1 << 13,
    S_ESC   = 20'd1 << 14,
    S_SQR   = 20'd1 << 15,
    S_SQI   = 20'd1 << 16,
    S_CMP   = 20'd1 << 17,
    S_OUT   = 20'd1 << 18,
    S_SPARE = 20'd1 << 19
  } state_t;

  state_t state;

  // configuration registers
  logic [7:0]        scale;
  logic [15:0]       max_iter;
  logic [2:0]        func_select;
  logic [SPAN_W-1:0] width;
  logic [SPAN_W-1:0] height;

  // derived constants of the current setup
  logic [7:0]        f;
  logic [8:0]        lim;
  logic [9:0]        f4;
  logic [SPAN_W-1:0] span_x;
  logic [SPAN_W-1:0] span_y;
  logic              fn_ok;
  logic [2:0]        pm1;

  // per-pixel working registers
  logic [9:0]               px;
  logic [9:0]               py;
  logic signed [C_W-1:0]    cr;
  logic signed [C_W-1:0]    ci;
  logic signed [ACC_W-1:0]  zr;
  logic signed [ACC_W-1:0]  zi;
  logic [MULA_W-1:0]        wr;
  logic [MULA_W-1:0]        wi;
  logic [MULA_W-1:0]        tre;
  logic [2:0]               k;
  logic [15:0]              iter;
  logic                     inside_flag;
  div_tag_t                 tag;

  mac_cmd_t                 mcmd;
  logic signed [ACC_W-1:0]  acc;
  div_cmd_t                 dcmd;
  logic                     div_done;
  logic signed [ACC_W-1:0]  div_q;
  logic signed [C_W-1:0]    c_val;
  logic                     z_big;
  logic [MULA_W-1:0]        wi_fin;

  function automatic logic [ACC_W-1:0] mag64(input logic signed [ACC_W-1:0] v);
    return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
  endfunction

  assign f      = (scale == 8'd0) ? 8'd1 : scale;
  assign lim    = {f, 1'b0};
  assign f4     = {f, 2'b00};
  assign span_x = (width  < SPAN_W'(2)) ? SPAN_W'(1) : width  - SPAN_W'(1);
  assign span_y = (height < SPAN_W'(2)) ? SPAN_W'(1) : height - SPAN_W'(1);
  assign fn_ok  = (func_select >= FN_ABS_IMAG) && (func_select <= FN_POW_MAX);
  // fn 1 squares like fn 2
  assign pm1    = (func_select == FN_ABS_IMAG) ? 3'd1 : func_select - 3'd1;

  // escape box test on the current z
  assign z_big  = (mag64(zr) > ACC_W'(lim)) || (mag64(zi) > ACC_W'(lim));
  // mapped coordinate: quotient minus 2*scale
  assign c_val  = $signed(div_q[C_W-1:0]) - $signed(C_W'(lim));
  // burning-ship variant folds the imaginary part
  assign wi_fin = (func_select == FN_ABS_IMAG && wi[MULA_W-1]) ? MULA_W'(0) - wi : wi;

  assign s_tready = (state == S_IDLE);

  // operand selection for the shared mac and divider
  always_comb begin
    mcmd.op       = MAC_HOLD;
    mcmd.a        = '0;
    mcmd.b        = '0;
    dcmd.start    = 1'b0;
    dcmd.dividend = '0;
    dcmd.divisor  = span_x;
    unique case (state)
      S_MAPX: begin
        mcmd.op = MAC_LOAD;
        mcmd.a  = MULA_W'(f4);
        mcmd.b  = {2'b00, px};
      end
      S_MAPY: begin
        mcmd.op = MAC_LOAD;
        mcmd.a  = MULA_W'(f4);
        mcmd.b  = {2'b00, py};
      end
      S_DMX: begin
        dcmd.start    = 1'b1;
        dcmd.dividend = acc;
        dcmd.divisor  = span_x;
      end
      S_DMY: begin
        dcmd.start    = 1'b1;
        dcmd.dividend = acc;
        dcmd.divisor  = span_y;
      end
      // (wr + j wi) * (a + j b)
      S_CM0: begin
        mcmd.op = MAC_LOAD;
        mcmd.a  = wr;
        mcmd.b  = zr[MULB_W-1:0];
      end
      S_CM1: begin
        mcmd.op = MAC_SUB;
        mcmd.a  = wi;
        mcmd.b  = zi[MULB_W-1:0];
      end
      S_CM2: begin
        mcmd.op = MAC_LOAD;
        mcmd.a  = wr;
        mcmd.b  = zi[MULB_W-1:0];
      end
      S_CM3: begin
        mcmd.op = MAC_ADD;
        mcmd.a  = wi;
        mcmd.b  = zr[MULB_W-1:0];
      end
      S_DRE: begin
        dcmd.start    = 1'b1;
        dcmd.dividend = ACC_W'($signed(wr));
        dcmd.divisor  = SPAN_W'(f);
      end
      S_DIM: begin
        dcmd.start    = 1'b1;
        dcmd.dividend = ACC_W'($signed(wi_fin));
        dcmd.divisor  = SPAN_W'(f);
      end
      // acc = zr^2 + zi^2 - 4*scale^2
      S_ESC: begin
        mcmd.op = MAC_LOAD;
        mcmd.a  = MULA_W'(lim);
        mcmd.b  = MULB_W'(0) - MULB_W'(lim);
      end
      S_SQR: begin
        mcmd.op = MAC_ADD;
        mcmd.a  = zr[MULA_W-1:0];
        mcmd.b  = zr[MULB_W-1:0];
      end
      S_SQI: begin
        mcmd.op = MAC_ADD;
        mcmd.a  = zi[MULA_W-1:0];
        mcmd.b  = zi[MULB_W-1:0];
      end
      default: begin
        mcmd.op = MAC_HOLD;
      end
    endcase
  end

  etfp_mac u_mac (
    .clk (clk),
    .cmd (mcmd),
    .acc (acc)
  );

  etfp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (dcmd),
    .done     (div_done),
    .quotient (div_q)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      scale       <= 8'd50;
      max_iter    <= 16'd50;
      func_select <= 3'd2;
      width       <= SPAN_W'(39);
      height      <= SPAN_W'(39);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SCALE:    scale       <= cfg_data[7:0];
        REG_MAX_ITER: max_iter    <= cfg_data;
        REG_FUNC:     func_select <= cfg_data[2:0];
        REG_WIDTH:    width       <= cfg_data[SPAN_W-1:0];
        REG_HEIGHT:   height      <= cfg_data[SPAN_W-1:0];
        default:      scale       <= scale;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // the output state loads a fresh result itself
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_MAPX;
          end
        end
        S_MAPX:  state <= S_DMX;
        S_DMX:   state <= S_DWAIT;
        S_MAPY:  state <= S_DMY;
        S_DMY:   state <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            unique case (tag)
              TAG_CX:  state <= S_MAPY;
              TAG_CY:  state <= S_HEAD;
              TAG_ZR:  state <= S_DIM;
              default: state <= S_ESC;
            endcase
          end
        end
        S_HEAD: begin
          if (iter == max_iter || !fn_ok || z_big) begin
            state <= S_OUT;
          end else begin
            state <= S_CM0;
          end
        end
        S_CM0: state <= S_CM1;
        S_CM1: state <= S_CM2;
        S_CM2: state <= S_CM3;
        S_CM3: state <= S_CM4;
        S_CM4: state <= (k + 3'd1 == pm1) ? S_DRE : S_CM0;
        S_DRE: state <= S_DWAIT;
        S_DIM: state <= S_DWAIT;
        S_ESC: state <= z_big ? S_OUT : S_SQR;
        S_SQR: state <= S_SQI;
        S_SQI: state <= S_CMP;
        S_CMP: state <= (acc > 0) ? S_OUT : S_HEAD;
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        px <= s_tdata[9:0];
        py <= s_tdata[19:10];
      end
      S_DMX: tag <= TAG_CX;
      S_DMY: tag <= TAG_CY;
      S_DRE: tag <= TAG_ZR;
      S_DIM: tag <= TAG_ZI;
      S_DWAIT: begin
        if (div_done) begin
          unique case (tag)
            TAG_CX: begin
              cr <= c_val;
              zr <= ACC_W'(c_val);
            end
            TAG_CY: begin
              ci   <= c_val;
              zi   <= ACC_W'(c_val);
              iter <= '0;
            end
            TAG_ZR:  zr <= div_q + ACC_W'(cr);
            default: zi <= div_q + ACC_W'(ci);
          endcase
        end
      end
      S_HEAD: begin
        // out of steps or unknown function: inside; start box exceeded: escaped
        inside_flag <= (iter == max_iter) || !fn_ok;
        wr          <= zr[MULA_W-1:0];
        wi          <= zi[MULA_W-1:0];
        k           <= '0;
      end
      S_CM2: tre <= acc[MULA_W-1:0];
      S_CM4: begin
        wi <= acc[MULA_W-1:0];
        wr <= tre;
        k  <= k + 3'd1;
      end
      S_ESC: inside_flag <= 1'b0;
      S_CMP: begin
        inside_flag <= 1'b0;
        iter        <= iter + 16'd1;
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {7'd0, inside_flag};
        end
      end
      default: k <= k;
    endcase
  end

`include "assert_macros.svh"

  `ASSERT_IMPL(a_accept_starts_map, s_tvalid && s_tready, ##1 state == S_MAPX, "accepted pixel did not start mapping")
  `ASSERT_IMPL(a_div_done_waited, div_done, state == S_DWAIT, "divider finished outside its wait state")
  `ASSERT_IMPL(a_cmul_needs_fn, state == S_CM0, fn_ok, "complex multiply for an unknown function")
  `ASSERT_CLK(a_result_from_out, $rose(m_tvalid) |-> $past(state == S_OUT), "result raised outside output state")

endmodule

### tb/tb_top.sv
// self-checking testbench for the escape-time fractal pixel block
`timescale 1ns / 100ps

module tb_top;
  import etfp_pkg::*;

  localparam int CYCLE_LIMIT = 30_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = REG_SCALE;
  logic [15:0] cfg_data = '0;

  escape_time_fractal_pixel u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // shadow copy of the configuration registers, reset values
  logic [7:0]  sh_scale    = 8'd50;
  logic [15:0] sh_max_iter = 16'd50;
  logic [2:0]  sh_func     = 3'd2;
  logic [10:0] sh_width    = 11'd39;
  logic [10:0] sh_height   = 11'd39;

  bit   inside_q[$];   // expected inside flags, oldest first
  int   errors = 0;
  int   cycles = 0;
  bit   quiet = 1'b0;  // no idling on either side near the end

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic longint abs_l(input longint v);
    return v < 0 ? -v : v;
  endfunction

  // pixel index to fixed-point coordinate, truncating division
  function automatic longint pixel_to_coord(input longint pix, input longint size,
                                            input longint unit);
    longint span;
    span = (size < 2) ? 1 : size - 1;
    return -2 * unit + (pix * 4 * unit) / span;
  endfunction

  // iterates z <- f(z) + c and tells whether the point stayed bounded
  function automatic bit pixel_is_inside(input logic [9:0] px, input logic [9:0] py);
    longint unit, lim, cr, ci, a, b, a2, b2, zr, zi, nr, ni;
    bit     fn_live;
    unit = (sh_scale == 0) ? 1 : longint'(sh_scale);
    lim  = 2 * unit;
    cr   = pixel_to_coord(px, sh_width, unit);
    ci   = pixel_to_coord(py, sh_height, unit);
    zr   = cr;
    zi   = ci;
    fn_live = (sh_func >= FN_ABS_IMAG) && (sh_func <= FN_POW_MAX);
    for (int i = 0; i < sh_max_iter; i++) begin
      // start point outside the box escapes before any step
      if (fn_live && (abs_l(zr) > lim || abs_l(zi) > lim)) return 1'b0;
      a = zr; b = zi; a2 = a * a; b2 = b * b;
      case (sh_func)
        3'd1: begin
          nr = (a2 - b2) / unit + cr;
          ni = abs_l(2 * a * b) / unit + ci;
        end
        3'd2: begin
          nr = (a2 - b2) / unit + cr;
          ni = (2 * a * b) / unit + ci;
        end
        3'd3: begin
          nr = (a2 * a - 3 * a * b2) / unit + cr;
          ni = (3 * a2 * b - b2 * b) / unit + ci;
        end
        3'd4: begin
          nr = (a2 * a2 - (6 * a2 - b2) * b2) / unit + cr;
          ni = (4 * a * b * (a2 - b2)) / unit + ci;
        end
        3'd5: begin
          nr = (a2 * a2 * a + a * b2 * (5 * b2 - 10 * a2)) / unit + cr;
          ni = (b * (5 * a2 * (a2 - 2 * b2) + b2 * b2)) / unit + ci;
        end
        3'd6: begin
          nr = (a2 * a2 * a2 - 15 * (a2 * a2 * b2) + 15 * (a2 * b2 * b2)
                - b2 * b2 * b2) / unit + cr;
          ni = (6 * (a2 * a2 * a) * b - 20 * (a2 * a) * (b2 * b)
                + 6 * a * (b2 * b2 * b)) / unit + ci;
        end
        default: begin
          // unknown function collapses z to the origin
          nr = 0;
          ni = 0;
        end
      endcase
      zr = nr;
      zi = ni;
      if (abs_l(zr) > lim || abs_l(zi) > lim || zr * zr + zi * zi > 4 * unit * unit)
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // one pixel transaction; called at a falling edge, returns at a falling edge
  task automatic send_pixel(input logic [9:0] px, input logic [9:0] py,
                            input bit typed, input bit typed_inside);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, py, px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    inside_q.push_back(typed ? typed_inside : pixel_is_inside(px, py));
    @(negedge clk);
  endtask

  // register write once the block has drained; called at a falling edge
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    s_tvalid <= 1'b0;
    while (inside_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_SCALE:    sh_scale    = val[7:0];
      REG_MAX_ITER: sh_max_iter = val;
      REG_FUNC:     sh_func     = val[2:0];
      REG_WIDTH:    sh_width    = val[10:0];
      REG_HEIGHT:   sh_height   = val[10:0];
      default: ;
    endcase
  endtask

  // directed table: either a register write or a pixel, expected flag typed in where obvious
  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [15:0] val;
    logic [9:0]  px;
    logic [9:0]  py;
    bit          typed;
    bit          exp_inside;
  } step_row_t;

  step_row_t plan[$] = '{
    '{0, REG_SCALE, 0, 0, 0, 1, 0},          // corner, escapes on the first step
    '{0, REG_SCALE, 0, 19, 19, 1, 1},        // center maps to c = 0
    '{0, REG_SCALE, 0, 1023, 1023, 1, 0},    // beyond the size, start point outside
    '{0, REG_SCALE, 0, 38, 0, 0, 0},
    '{0, REG_SCALE, 0, 10, 25, 0, 0},
    '{1, REG_FUNC, 1, 0, 0, 0, 0},           // burning ship form
    '{0, REG_SCALE, 0, 5, 19, 0, 0},
    '{0, REG_SCALE, 0, 30, 12, 0, 0},
    '{1, REG_FUNC, 3, 0, 0, 0, 0},
    '{0, REG_SCALE, 0, 20, 20, 0, 0},
    '{1, REG_FUNC, 4, 0, 0, 0, 0},
    '{0, REG_SCALE, 0, 22, 15, 0, 0},
    '{1, REG_FUNC, 5, 0, 0, 0, 0},
    '{0, REG_SCALE, 0, 19, 21, 0, 0},
    '{1, REG_FUNC, 6, 0, 0, 0, 0},
    '{0, REG_SCALE, 0, 18, 18, 0, 0},
    '{1, REG_FUNC, 0, 0, 0, 0, 0},           // unknown function: always inside
    '{0, REG_SCALE, 0, 3, 7, 1, 1},
    '{1, REG_FUNC, 7, 0, 0, 0, 0},
    '{0, REG_SCALE, 0, 1023, 0, 1, 1},
    '{1, REG_FUNC, 2, 0, 0, 0, 0},
    '{1, REG_MAX_ITER, 0, 0, 0, 0, 0},       // zero step limit: always inside
    '{0, REG_SCALE, 0, 0, 0, 1, 1},
    '{1, REG_MAX_ITER, 10, 0, 0, 0, 0},
    '{1, REG_SCALE, 0, 0, 0, 0, 0},          // scale zero acts as one
    '{0, REG_SCALE, 0, 1, 1, 0, 0},
    '{1, REG_SCALE, 255, 0, 0, 0, 0},
    '{1, REG_WIDTH, 0, 0, 0, 0, 0},          // sizes below two divide by one
    '{1, REG_HEIGHT, 1, 0, 0, 0, 0},
    '{0, REG_SCALE, 0, 1, 0, 0, 0},
    '{1, REG_WIDTH, 1024, 0, 0, 0, 0},
    '{1, REG_HEIGHT, 1024, 0, 0, 0, 0},
    '{0, REG_SCALE, 0, 1023, 511, 0, 0},
    '{1, REG_MAX_ITER, 65535, 0, 0, 0, 0},   // longest limit, only quick escapes
    '{0, REG_SCALE, 0, 0, 0, 1, 0},
    '{1, REG_FUNC, 6, 0, 0, 0, 0},
    '{0, REG_SCALE, 0, 0, 1023, 0, 0}
  };

  // stimulus
  initial begin
    int unsigned w, h, xs, ys;
    logic [9:0]  px, py;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].val);
      else send_pixel(plan[i].px, plan[i].py, plan[i].typed, plan[i].exp_inside);
    end

    // random phases, each with a fresh configuration
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 11) quiet = 1'b1;
      write_reg(REG_SCALE, (ph == 1) ? 16'd255 : (ph == 2) ? 16'd1 : 16'($urandom_range(0, 255)));
      write_reg(REG_MAX_ITER, (ph == 3) ? 16'd0 : 16'($urandom_range(1, 6)));
      write_reg(REG_FUNC, 16'(ph % 8));
      w = (ph == 4) ? 2047 : (ph == 5) ? 1 : $urandom_range(2, 1024);
      h = (ph == 4) ? 0 : (ph == 5) ? 1024 : $urandom_range(2, 1024);
      write_reg(REG_WIDTH, 16'(w));
      write_reg(REG_HEIGHT, 16'(h));
      xs = (w < 2) ? 1 : ((w > 1024) ? 1024 : w - 1);
      ys = (h < 2) ? 1 : ((h > 1024) ? 1024 : h - 1);
      for (int n = 0; n < 105; n++) begin
        if ($urandom_range(0, 7) == 0) begin
          px = 10'($urandom);
          py = 10'($urandom);
        end else begin
          px = 10'($urandom_range(0, xs));
          py = 10'($urandom_range(0, ys));
        end
        send_pixel(px, py, 1'b0, 1'b0);
      end
    end

    s_tvalid <= 1'b0;
    while (inside_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // result side stalls in random bursts
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!quiet && !rst && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 13);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (inside_q.size() == 0) begin
        report($sformatf("unexpected result inside=%0b", m_tdata[0]));
      end else begin
        if (m_tdata[0] !== inside_q[0])
          report($sformatf("inside got %0b want %0b", m_tdata[0], inside_q[0]));
        void'(inside_q.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
